>>> rtl/ccse_pkg.sv
// Shared types and constants for the cursor control sequence encoder.
// Command codes, byte codes, controller/datapath interface structs.
// No dependencies.
package ccse_pkg;

	// coordinate and digit store sizes
	localparam int COORD_W   = 16;
	localparam int MAX_DIGS  = 5;
	localparam int DIG_IDX_W = 3;
	localparam int CFG_IDX_W = 2;

	// reciprocal of ten for 16-bit operands: q = (v * RECIP10) >> RECIP_SH
	localparam logic [15:0] RECIP10  = 16'hCCCD;
	localparam int          RECIP_SH = 19;

	// command codes
	localparam logic [2:0] MODE_UP       = 3'd0;
	localparam logic [2:0] MODE_DOWN     = 3'd1;
	localparam logic [2:0] MODE_FORWARD  = 3'd2;
	localparam logic [2:0] MODE_BACKWARD = 3'd3;
	localparam logic [2:0] MODE_COL_ABS  = 3'd4;
	localparam logic [2:0] MODE_POSITION = 3'd5;
	localparam logic [2:0] MODE_LINE_ABS = 3'd6;
	localparam logic [2:0] MODE_UNUSED   = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CSI_EIGHT_BIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_DEFAULT_OK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_DEFAULT_OK   = 2'd2;

	// byte codes
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_CSI8  = 8'h9B;
	localparam logic [7:0] BYTE_BRKT  = 8'h5B;
	localparam logic [7:0] BYTE_SEMI  = 8'h3B;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;

	// which byte the datapath loads into the output register
	typedef enum logic [2:0] {
		SEL_INTRO,
		SEL_BRKT,
		SEL_ROW_DIG,
		SEL_SEMI,
		SEL_AMT_DIG,
		SEL_FINAL
	} byte_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic      load;     // capture an accepted command
		logic      conv;     // run one decimal conversion step
		logic      idx_clr;  // restart the digit index
		logic      idx_inc;  // advance the digit index
		logic      ld_out;   // load the output register
		byte_sel_t sel;
		logic      last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_mode_ok;    // incoming command is defined
		logic csi8;
		logic param_on;
		logic is_pos;
		logic conv_done;
		logic row_last_dig;
		logic amt_last_dig;
	} sts_t;

	// final byte of each command
	function automatic logic [7:0] final_byte(input logic [2:0] mode);
		logic [7:0] b;
		case (mode)
			MODE_UP:       b = 8'h41;
			MODE_DOWN:     b = 8'h42;
			MODE_FORWARD:  b = 8'h43;
			MODE_BACKWARD: b = 8'h44;
			MODE_COL_ABS:  b = 8'h47;
			MODE_POSITION: b = 8'h48;
			MODE_LINE_ABS: b = 8'h64;
			default:       b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/ccse_datapath.sv
// Datapath of the cursor control sequence encoder: config registers,
// decimal conversion by reciprocal multiply, digit stores and output word.
// Depends on ccse_pkg.
module ccse_datapath import ccse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic [2:0]           mode,
	input  logic [COORD_W-1:0]   amount,
	input  logic [COORD_W-1:0]   row,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [7:0]           out_byte,
	output logic                 last
);

	// split a value into quotient and remainder by ten
	function automatic logic [COORD_W+3:0] div10(input logic [COORD_W-1:0] v);
		logic [31:0]        prod;
		logic [COORD_W-1:0] q;
		logic [COORD_W-1:0] q10;
		logic [COORD_W-1:0] r;
		prod = 32'(v) * 32'(RECIP10);
		q    = COORD_W'(prod >> RECIP_SH);
		q10  = COORD_W'({q, 3'b000}) + COORD_W'({q, 1'b0});
		r    = v - q10;
		return {q, r[3:0]};
	endfunction

	logic                 csi8_q, col_ok_q, line_ok_q;
	logic [2:0]           mode_q;
	logic                 param_on_q;
	logic [COORD_W-1:0]   amt_v_q, row_v_q;
	logic                 amt_busy_q, row_busy_q;
	logic [3:0]           amt_dig_q [MAX_DIGS];
	logic [3:0]           row_dig_q [MAX_DIGS];
	logic [DIG_IDX_W-1:0] amt_cnt_q, row_cnt_q;
	logic [DIG_IDX_W-1:0] idx_q;
	logic [COORD_W+3:0]   amt_div, row_div;
	logic [DIG_IDX_W-1:0] amt_rd, row_rd;
	logic                 param_in;
	logic [7:0]           byte_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csi8_q    <= 1'b0;
			col_ok_q  <= 1'b0;
			line_ok_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CSI_EIGHT_BIT:     csi8_q    <= cfg_data;
				CFG_COLUMN_DEFAULT_OK: col_ok_q  <= cfg_data;
				CFG_LINE_DEFAULT_OK:   line_ok_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whether the command carries its parameter(s)
	always_comb begin
		case (mode)
			MODE_COL_ABS:  param_in = (amount != COORD_W'(1)) || !col_ok_q;
			MODE_LINE_ABS: param_in = (amount != COORD_W'(1)) || !line_ok_q;
			MODE_POSITION: param_in = (amount != COORD_W'(1)) || (row != COORD_W'(1));
			default:       param_in = (amount != COORD_W'(1));
		endcase
	end

	assign amt_div = div10(amt_v_q);
	assign row_div = div10(row_v_q);

	// command capture and conversion, least significant digit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amt_busy_q <= 1'b0;
			row_busy_q <= 1'b0;
			amt_cnt_q  <= '0;
			row_cnt_q  <= '0;
		end else if (cmd.load) begin
			amt_busy_q <= 1'b1;
			row_busy_q <= 1'b1;
			amt_cnt_q  <= '0;
			row_cnt_q  <= '0;
		end else if (cmd.conv) begin
			if (amt_busy_q) begin
				amt_cnt_q  <= amt_cnt_q + DIG_IDX_W'(1);
				amt_busy_q <= (amt_div[COORD_W+3:4] != '0);
			end
			if (row_busy_q) begin
				row_cnt_q  <= row_cnt_q + DIG_IDX_W'(1);
				row_busy_q <= (row_div[COORD_W+3:4] != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= mode;
			param_on_q <= param_in;
			amt_v_q    <= amount;
			row_v_q    <= row;
		end else if (cmd.conv) begin
			if (amt_busy_q) begin
				amt_dig_q[amt_cnt_q] <= amt_div[3:0];
				amt_v_q              <= amt_div[COORD_W+3:4];
			end
			if (row_busy_q) begin
				row_dig_q[row_cnt_q] <= row_div[3:0];
				row_v_q              <= row_div[COORD_W+3:4];
			end
		end
	end

	// digit index, counted from the most significant digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.idx_clr)
			idx_q <= '0;
		else if (cmd.idx_inc)
			idx_q <= idx_q + DIG_IDX_W'(1);
	end

	assign amt_rd = amt_cnt_q - DIG_IDX_W'(1) - idx_q;
	assign row_rd = row_cnt_q - DIG_IDX_W'(1) - idx_q;

	// output byte select
	always_comb begin
		case (cmd.sel)
			SEL_INTRO:   byte_d = csi8_q ? BYTE_CSI8 : BYTE_ESC;
			SEL_BRKT:    byte_d = BYTE_BRKT;
			SEL_ROW_DIG: byte_d = BYTE_ZERO | {4'h0, row_dig_q[row_rd]};
			SEL_SEMI:    byte_d = BYTE_SEMI;
			SEL_AMT_DIG: byte_d = BYTE_ZERO | {4'h0, amt_dig_q[amt_rd]};
			SEL_FINAL:   byte_d = final_byte(mode_q);
			default:     byte_d = BYTE_ESC;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_byte <= byte_d;
			last     <= cmd.last;
		end
	end

	assign sts.in_mode_ok   = (mode != MODE_UNUSED);
	assign sts.csi8         = csi8_q;
	assign sts.param_on     = param_on_q;
	assign sts.is_pos       = (mode_q == MODE_POSITION);
	assign sts.conv_done    = !amt_busy_q && !row_busy_q;
	assign sts.row_last_dig = (idx_q == row_cnt_q - DIG_IDX_W'(1));
	assign sts.amt_last_dig = (idx_q == amt_cnt_q - DIG_IDX_W'(1));

endmodule

>>> rtl/ccse_ctrl.sv
// Controller of the cursor control sequence encoder: walks each command
// through conversion and byte emission, owns the handshakes.
// Depends on ccse_pkg.
module ccse_ctrl import ccse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CONV = 8'b0000_0010,
		S_ESC  = 8'b0000_0100,
		S_BRKT = 8'b0000_1000,
		S_ROW  = 8'b0001_0000,
		S_SEMI = 8'b0010_0000,
		S_AMT  = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   slot_free;
	state_t after_intro;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// first state after the introducer
	always_comb begin
		if (!sts.param_on)
			after_intro = S_FIN;
		else if (sts.is_pos)
			after_intro = S_ROW;
		else
			after_intro = S_AMT;
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '{load: 1'b0, conv: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0,
		            ld_out: 1'b0, sel: SEL_INTRO, last: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.in_mode_ok)
						state_d = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv = 1'b1;
				if (sts.conv_done)
					state_d = S_ESC;
			end
			S_ESC: begin
				cmd.sel     = SEL_INTRO;
				cmd.idx_clr = 1'b1;
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_d    = sts.csi8 ? after_intro : S_BRKT;
				end
			end
			S_BRKT: begin
				cmd.sel = SEL_BRKT;
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_d    = after_intro;
				end
			end
			S_ROW: begin
				cmd.sel = SEL_ROW_DIG;
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					if (sts.row_last_dig) begin
						cmd.idx_clr = 1'b1;
						state_d     = S_SEMI;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_SEMI: begin
				cmd.sel = SEL_SEMI;
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_d    = S_AMT;
				end
			end
			S_AMT: begin
				cmd.sel = SEL_AMT_DIG;
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					if (sts.amt_last_dig)
						state_d = S_FIN;
					else
						cmd.idx_inc = 1'b1;
				end
			end
			S_FIN: begin
				cmd.sel  = SEL_FINAL;
				cmd.last = 1'b1;
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// output word valid: set on load, cleared when taken
	always_comb begin
		if (cmd.ld_out)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

>>> rtl/cursor_control_sequence_encoder.sv
// Cursor control sequence encoder, top level.
// Joins the controller and the datapath. Depends on ccse_pkg,
// ccse_datapath and ccse_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready, mode, amount, row) takes one cursor
//   command. The output channel (out_valid/out_ready, out_byte, last) gives
//   its CSI control sequence one byte per word, last set on the final byte.
//   The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   csi_eight_bit (0), column_default_ok (1), line_default_ok (2); it is
//   always ready and is to be used only while the encoder is idle.
// Timing:
//   A command is taken in the idle state, then the decimal conversion runs one
//   digit per cycle for amount and row together until the longer value is
//   converted, and the controller sees it finish; then one byte leaves per
//   cycle while the receiver takes each word: 2 to 14 bytes.
//   A command with the undefined mode code is taken and dropped.
// Reset clears the config registers to zero and empties the output word.
// When the receiver stalls the output word holds and emission pauses;
// the next command is taken once the final byte sits in the output word.
module cursor_control_sequence_encoder import ccse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           mode,
	input  logic [COORD_W-1:0]   amount,
	input  logic [COORD_W-1:0]   row,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 last
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ccse_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.amount    (amount),
		.row       (row),
		.cmd       (cmd),
		.sts       (sts),
		.out_byte  (out_byte),
		.last      (last)
	);

	ccse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

endmodule

>>> tb/sv/ccse_tb_pkg.sv
// Scoreboard for the cursor control sequence encoder testbench.
// Predicts the CSI byte stream of each accepted command and checks output words.
// Depends on ccse_pkg for byte codes, command codes and register indexes.
package ccse_tb_pkg;
	import ccse_pkg::*;

	// final bytes of the cursor commands
	localparam logic [7:0] FIN_UP       = 8'h41;
	localparam logic [7:0] FIN_DOWN     = 8'h42;
	localparam logic [7:0] FIN_FORWARD  = 8'h43;
	localparam logic [7:0] FIN_BACKWARD = 8'h44;
	localparam logic [7:0] FIN_COL_ABS  = 8'h47;
	localparam logic [7:0] FIN_POSITION = 8'h48;
	localparam logic [7:0] FIN_LINE_ABS = 8'h64;

	class csi_byte_scoreboard;
		// local copy of the register file
		bit csi8;
		bit col_dflt;
		bit line_dflt;

		// expected output words, oldest first
		logic [7:0] seq_bytes[$];
		bit         seq_last[$];

		int errors;
		int commands;
		int dropped;
		int bytes_checked;

		function new();
			csi8 = 1'b0;
			col_dflt = 1'b0;
			line_dflt = 1'b0;
			errors = 0;
			commands = 0;
			dropped = 0;
			bytes_checked = 0;
		endfunction

		function int pending();
			return seq_bytes.size();
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic d);
			case (idx)
				CFG_CSI_EIGHT_BIT:     csi8 = d;
				CFG_COLUMN_DEFAULT_OK: col_dflt = d;
				CFG_LINE_DEFAULT_OK:   line_dflt = d;
				default: ;
			endcase
		endfunction

		function void push_byte(logic [7:0] b);
			seq_bytes.push_back(b);
			seq_last.push_back(1'b0);
		endfunction

		// decimal digits, most significant first, no leading zeros
		function void push_decimal(logic [COORD_W-1:0] v);
			logic [7:0]       digs[MAX_DIGS];
			logic [COORD_W-1:0] rest;
			int               n;
			rest = v;
			n = 0;
			do begin
				digs[n] = BYTE_ZERO + 8'(rest % COORD_W'(10));
				rest = rest / COORD_W'(10);
				n++;
			end while (rest != 0);
			while (n > 0) begin
				n--;
				push_byte(digs[n]);
			end
		endfunction

		// accepted command: work out its whole control sequence
		function void note_command(logic [2:0] m, logic [COORD_W-1:0] amt,
				logic [COORD_W-1:0] rw);
			logic [7:0] fin;
			if (m == MODE_UNUSED) begin
				dropped++;
				return;
			end
			commands++;
			if (csi8) begin
				push_byte(BYTE_CSI8);
			end else begin
				push_byte(BYTE_ESC);
				push_byte(BYTE_BRKT);
			end
			fin = FIN_LINE_ABS;
			case (m)
				MODE_UP, MODE_DOWN, MODE_FORWARD, MODE_BACKWARD: begin
					// relative moves drop a count of one
					if (amt != 1)
						push_decimal(amt);
					case (m)
						MODE_UP:      fin = FIN_UP;
						MODE_DOWN:    fin = FIN_DOWN;
						MODE_FORWARD: fin = FIN_FORWARD;
						default:      fin = FIN_BACKWARD;
					endcase
				end
				MODE_COL_ABS: begin
					if (amt != 1 || !col_dflt)
						push_decimal(amt);
					fin = FIN_COL_ABS;
				end
				MODE_POSITION: begin
					// row;column, both left out only at home
					if (amt != 1 || rw != 1) begin
						push_decimal(rw);
						push_byte(BYTE_SEMI);
						push_decimal(amt);
					end
					fin = FIN_POSITION;
				end
				default: begin
					if (amt != 1 || !line_dflt)
						push_decimal(amt);
					fin = FIN_LINE_ABS;
				end
			endcase
			seq_bytes.push_back(fin);
			seq_last.push_back(1'b1);
		endfunction

		// accepted output word against the oldest expectation
		task check_word(logic [7:0] b, logic l);
			logic [7:0] eb;
			bit         el;
			if (seq_bytes.size() == 0) begin
				report($sformatf("unexpected word byte=%02h last=%0b", b, l));
				return;
			end
			eb = seq_bytes.pop_front();
			el = seq_last.pop_front();
			bytes_checked++;
			if (b !== eb)
				report($sformatf("out_byte %02h, expected %02h", b, eb));
			if (l !== el)
				report($sformatf("last %0b on byte %02h, expected %0b", l, eb, el));
		endtask
	endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level testbench for cursor_control_sequence_encoder.
// Drives commands and register writes, predicts via ccse_tb_pkg scoreboard.
// Depends on ccse_pkg, ccse_tb_pkg and the encoder RTL.
module testbench;
	import ccse_pkg::*;
	import ccse_tb_pkg::*;

	localparam int IDLE_PCT    = 36;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE      = 30;
	localparam int WATCHDOG    = 3000;
	localparam int PHASE_ITEMS = 45;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic                 cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           mode;
	logic [COORD_W-1:0]   amount;
	logic [COORD_W-1:0]   row;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           out_byte;
	logic                 last;

	csi_byte_scoreboard sb = new();

	bit quiet;     // no idling on either side
	bit hold_req;  // ask the receiver for a long hold-off
	int idle_cycles;
	int settings_run;

	cursor_control_sequence_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.amount    (amount),
		.row       (row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sample every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_command(mode, amount, row);
			if (out_valid && out_ready)
				sb.check_word(out_byte, last);
		end
	end

	// watchdog on cycles without any accepted word
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no progress for %0d cycles, %0d words outstanding",
				WATCHDOG, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, quiet stretches, one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// one register write; entered and left at a falling edge
	task write_reg(logic [CFG_IDX_W-1:0] idx, logic d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task set_config(bit c8, bit col, bit line);
		write_reg(CFG_CSI_EIGHT_BIT, c8);
		write_reg(CFG_COLUMN_DEFAULT_OK, col);
		write_reg(CFG_LINE_DEFAULT_OK, line);
		cfg_valid <= 1'b0;
		@(negedge clk);
		settings_run++;
	endtask

	// offer one command, idling at random first
	task send_cmd(logic [2:0] m, logic [COORD_W-1:0] amt, logic [COORD_W-1:0] rw);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		amount   <= amt;
		row      <= rw;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// wait for every expected word, then let a dropped command finish
	task drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// coordinate values weighted towards digit-count boundaries and one
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return COORD_W'(1);
			1:       return COORD_W'(0);
			2:       return COORD_W'($urandom_range(0, 9));
			3:       return COORD_W'($urandom_range(10, 99));
			4:       return COORD_W'($urandom_range(100, 9999));
			5:       return 16'hFFFF;
			6:       return COORD_W'($urandom_range(10000, 65535));
			7:       return 16'(1) << $urandom_range(0, 15);
			default: return COORD_W'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		bit [2:0] cfg_bits;
		int       counted;
		logic [2:0] m;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_UP;
		amount    = '0;
		row       = '0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		settings_run = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, every command at one, extremes, home
		write_reg(CFG_SPARE, 1'b1);
		set_config(1'b0, 1'b0, 1'b0);
		for (int i = 0; i <= 6; i++)
			send_cmd(3'(i), 16'd1, 16'd1);
		send_cmd(MODE_UP, 16'd0, 16'd0);
		send_cmd(MODE_BACKWARD, 16'hFFFF, 16'hFFFF);
		send_cmd(MODE_POSITION, 16'hFFFF, 16'hFFFF);
		send_cmd(MODE_POSITION, 16'd0, 16'd0);
		send_cmd(MODE_POSITION, 16'd7, 16'd1);
		send_cmd(MODE_POSITION, 16'd1, 16'd7);
		send_cmd(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
		send_cmd(MODE_COL_ABS, 16'd10, 16'd0);
		send_cmd(MODE_LINE_ABS, 16'd0, 16'd0);
		drain();

		// directed: eight-bit introducer, defaults accepted
		set_config(1'b1, 1'b1, 1'b1);
		send_cmd(MODE_COL_ABS, 16'd1, 16'd0);
		send_cmd(MODE_LINE_ABS, 16'd1, 16'd0);
		send_cmd(MODE_POSITION, 16'd1, 16'd1);
		send_cmd(MODE_DOWN, 16'd1, 16'd0);
		send_cmd(MODE_FORWARD, 16'(99999 % 65536), 16'd0);
		send_cmd(MODE_LINE_ABS, 16'd2, 16'd0);
		drain();

		// random phases over a spread of register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       cfg_bits = 3'b000;
				1:       cfg_bits = 3'b111;
				2:       cfg_bits = 3'b110;
				3:       cfg_bits = 3'b001;
				4:       cfg_bits = 3'b100;
				default: cfg_bits = 3'($urandom_range(0, 7));
			endcase
			set_config(cfg_bits[2], cfg_bits[1], cfg_bits[0]);
			quiet = (ph == 1);
			if (ph == 3)
				hold_req = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(0, 19) == 0)
					m = MODE_UNUSED;
				else
					m = 3'($urandom_range(0, 6));
				send_cmd(m, pick_coord(), pick_coord());
				if (m != MODE_UNUSED)
					counted++;
			end
			drain();
			quiet = 1'b0;
		end

		$display("Ran %0d commands (%0d undefined, dropped) under %0d register settings;",
			sb.commands, sb.dropped, settings_run);
		$display("checked %0d output bytes including a long receiver hold-off.",
			sb.bytes_checked);
		while (sb.pending() != 0)
			sb.report($sformatf("byte %02h never arrived", sb.seq_bytes.pop_front()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
